>>> design/assert_macros.svh
// Assertion macros for the RTL; empty when synthesizing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is active.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, evaluated also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> design/dhcpx_pkg.sv
// Constants of the DHCP option extractor: option codes and parser phases.
`default_nettype none
package dhcpx_pkg;

	// Option codes
	localparam logic [7:0] OPT_PAD    = 8'd0;
	localparam logic [7:0] OPT_MASK   = 8'd1;
	localparam logic [7:0] OPT_DNS    = 8'd6;
	localparam logic [7:0] OPT_LEASE  = 8'd51;
	localparam logic [7:0] OPT_TYPE   = 8'd53;
	localparam logic [7:0] OPT_SERVER = 8'd54;
	localparam logic [7:0] OPT_END    = 8'd255;

	// Address option length
	localparam logic [7:0] ADDR_LEN = 8'd4;

	// Highest valid message type
	localparam logic [31:0] MSG_TYPE_MAX = 32'd8;

	// Parser phases
	localparam logic [1:0] PH_CODE  = 2'd0;
	localparam logic [1:0] PH_LEN   = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_DRAIN = 2'd3;

	// Result tdata width, padded to whole bytes
	localparam int RES_BITS  = 201;
	localparam int RES_WIDTH = 208;

endpackage
`default_nettype wire

>>> design/dhcp_option_extractor.sv
// Streaming DHCP option parser that reports one result per options area.
`default_nettype none
`include "assert_macros.svh"
// DHCP option extractor. Feed the options area (after the magic cookie) one byte
// per request on the s_ side, with s_tlast on the last byte of each message.
// For each byte, parse state is updated and the result is built in
// the same cycle, and the result register on the m_ side is loaded at the edge
// that accepts the END byte, or the frame's last byte when END never came.
// A result is therefore seen in the cycle after the byte that closes it. The
// input side keeps taking one byte per cycle while a result waits, and only
// stalls when a new result is due and the held one has not been taken.
// DNS_SLOT_COUNT sets how many DNS server addresses are stored (at most three
// are reported).
module dhcp_option_extractor
	import dhcpx_pkg::*;
#(
	parameter int DNS_SLOT_COUNT = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [7:0]           s_tdata,  // [7:0] option_byte
	input  wire logic                 s_tlast,  // frame_end
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// [3:0] message_type, [35:4] server_ident, [36] server_ident_ok,
	// [68:37] lease_seconds, [69] lease_ok, [101:70] net_mask, [102] net_mask_ok,
	// [104:103] dns_count, [136:105] dns_first, [168:137] dns_second,
	// [200:169] dns_third, [207:201] zero
	output logic [RES_WIDTH-1:0]      m_tdata,
	output logic                      m_tuser   // malformed
);

	localparam int DNS_CAP = (DNS_SLOT_COUNT < 3) ? DNS_SLOT_COUNT : 3;

	// Parse state
	logic [1:0]  phase_q;
	logic [7:0]  code_q;
	logic [7:0]  left_q;
	logic [7:0]  idx_q;
	logic [31:0] shift_q;
	logic [3:0]  type_q;
	logic [31:0] srv_q, lease_q, mask_q;
	logic        srv_ok_q, lease_ok_q, mask_ok_q;
	logic [1:0]  cnt_q;
	logic [31:0] dns_slot_q [DNS_SLOT_COUNT];

	// Result register
	logic                 out_valid_q;
	logic [RES_WIDTH-1:0] out_data_q;
	logic                 out_bad_q;

	logic accept;
	logic [7:0] b;

	// Values after this byte's step
	logic [1:0]  p_phase;
	logic [7:0]  p_code, p_left, p_idx;
	logic [31:0] p_shift;
	logic [3:0]  p_type;
	logic [31:0] p_srv, p_lease, p_mask;
	logic        p_srv_ok, p_lease_ok, p_mask_ok;
	logic [1:0]  p_cnt;

	logic        commit;
	logic [7:0]  c_len;
	logic [31:0] c_val;
	logic [31:0] shift_new;
	logic [5:0]  dns_n;
	logic        four;
	logic        dns_wr;
	logic        emit, emit_end, bad;
	logic        clear;

	logic [31:0] slot_next [DNS_SLOT_COUNT];
	logic [31:0] dns_out [3];
	logic [RES_BITS-1:0] res;

	// Take a byte unless it closes a result while the held one is still waiting
	assign b         = s_tdata;
	assign s_tready  = !out_valid_q || m_tready || !emit;
	assign accept    = s_tvalid && s_tready;
	assign shift_new = {shift_q[23:0], b};
	assign dns_wr    = accept && (phase_q == PH_VALUE) && (code_q == OPT_DNS)
		&& (idx_q[1:0] == 2'd3);

	// Step the parser for one byte and commit finished options
	always_comb begin
		p_phase    = phase_q;
		p_code     = code_q;
		p_left     = left_q;
		p_idx      = idx_q;
		p_shift    = shift_q;
		p_type     = type_q;
		p_srv      = srv_q;
		p_lease    = lease_q;
		p_mask     = mask_q;
		p_srv_ok   = srv_ok_q;
		p_lease_ok = lease_ok_q;
		p_mask_ok  = mask_ok_q;
		p_cnt      = cnt_q;
		commit     = 1'b0;
		c_len      = 8'd0;
		c_val      = 32'd0;
		emit_end   = 1'b0;

		unique case (phase_q)
			PH_CODE: begin
				if (b == OPT_END) begin
					emit_end = 1'b1;
				end else if (b != OPT_PAD) begin
					p_code  = b;
					p_phase = PH_LEN;
				end
			end
			PH_LEN: begin
				p_left  = b;
				p_idx   = 8'd0;
				p_shift = 32'd0;
				if (b == 8'd0) begin
					commit = 1'b1;
				end else begin
					p_phase = PH_VALUE;
				end
			end
			PH_VALUE: begin
				p_shift = shift_new;
				p_idx   = idx_q + 8'd1;
				p_left  = left_q - 8'd1;
				if (left_q == 8'd1) begin
					commit = 1'b1;
					c_len  = idx_q + 8'd1;
					c_val  = shift_new;
				end
			end
			default: begin
			end
		endcase

		// Keep the finished option
		four  = (c_len == ADDR_LEN);
		dns_n = c_len[7:2];
		if (commit) begin
			p_phase = PH_CODE;
			unique case (code_q)
				OPT_TYPE: begin
					p_type = (c_len == 8'd1 && c_val >= 32'd1 && c_val <= MSG_TYPE_MAX)
						? c_val[3:0] : 4'd0;
				end
				OPT_SERVER: begin
					p_srv_ok = four;
					p_srv    = four ? c_val : 32'd0;
				end
				OPT_LEASE: begin
					p_lease_ok = four;
					p_lease    = four ? c_val : 32'd0;
				end
				OPT_MASK: begin
					p_mask_ok = four;
					p_mask    = four ? c_val : 32'd0;
				end
				OPT_DNS: begin
					if (c_len[1:0] != 2'd0) begin
						p_cnt = 2'd0;
					end else if (dns_n > 6'(DNS_CAP)) begin
						p_cnt = 2'(DNS_CAP);
					end else begin
						p_cnt = dns_n[1:0];
					end
				end
				default: begin
				end
			endcase
		end

		// Report on END, or on a frame end that is not draining
		bad   = !emit_end && s_tlast && (p_phase != PH_DRAIN);
		emit  = emit_end || bad;
		clear = emit_end || s_tlast;
	end

	// Slot values including this byte's write
	for (genvar k = 0; k < DNS_SLOT_COUNT; k++) begin : g_slot
		logic we;
		assign we = dns_wr && (idx_q[7:2] == 6'(k));
		assign slot_next[k] = we ? shift_new : dns_slot_q[k];

		always_ff @(posedge clk) begin
			if (we) begin
				dns_slot_q[k] <= shift_new;
			end
		end
	end

	// Reported DNS addresses, zero where the count does not reach
	for (genvar k = 0; k < 3; k++) begin : g_dns
		if (k < DNS_SLOT_COUNT) begin : g_on
			assign dns_out[k] = (2'(k) < p_cnt) ? slot_next[k] : 32'd0;
		end else begin : g_off
			assign dns_out[k] = 32'd0;
		end
	end

	assign res = {dns_out[2], dns_out[1], dns_out[0], p_cnt, p_mask_ok, p_mask,
		p_lease_ok, p_lease, p_srv_ok, p_srv, p_type};

	// Advance parse state on each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_CODE;
			code_q     <= 8'd0;
			left_q     <= 8'd0;
			idx_q      <= 8'd0;
			shift_q    <= 32'd0;
			type_q     <= 4'd0;
			srv_q      <= 32'd0;
			lease_q    <= 32'd0;
			mask_q     <= 32'd0;
			srv_ok_q   <= 1'b0;
			lease_ok_q <= 1'b0;
			mask_ok_q  <= 1'b0;
			cnt_q      <= 2'd0;
		end else if (accept) begin
			if (clear) begin
				phase_q    <= (emit_end && !s_tlast) ? PH_DRAIN : PH_CODE;
				code_q     <= 8'd0;
				left_q     <= 8'd0;
				idx_q      <= 8'd0;
				shift_q    <= 32'd0;
				type_q     <= 4'd0;
				srv_q      <= 32'd0;
				lease_q    <= 32'd0;
				mask_q     <= 32'd0;
				srv_ok_q   <= 1'b0;
				lease_ok_q <= 1'b0;
				mask_ok_q  <= 1'b0;
				cnt_q      <= 2'd0;
			end else begin
				phase_q    <= p_phase;
				code_q     <= p_code;
				left_q     <= p_left;
				idx_q      <= p_idx;
				shift_q    <= p_shift;
				type_q     <= p_type;
				srv_q      <= p_srv;
				lease_q    <= p_lease;
				mask_q     <= p_mask;
				srv_ok_q   <= p_srv_ok;
				lease_ok_q <= p_lease_ok;
				mask_ok_q  <= p_mask_ok;
				cnt_q      <= p_cnt;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_data_q <= {(RES_WIDTH - RES_BITS)'(0), res};
			out_bad_q  <= bad;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_bad_q;

	`ASSERT_ALWAYS(a_stall_only_when_full, clk, !s_tready |-> (m_tvalid && !m_tready), "input stalled with room for a result")
	`ASSERT_CLK(a_hold_result, clk, arst_n, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "held result changed before taken")
	`ASSERT_CLK(a_type_range, clk, arst_n, m_tvalid |-> (m_tdata[3:0] <= 4'd8), "message type out of range")
	`ASSERT_CLK(a_dns_cap, clk, arst_n, m_tvalid |-> (m_tdata[104:103] <= 2'(DNS_CAP)), "DNS count above cap")
	`ASSERT_CLK(a_srv_zero, clk, arst_n, (m_tvalid && !m_tdata[36]) |-> (m_tdata[35:4] == 32'd0), "server value without ok")
	`ASSERT_CLK(a_frame_restart, clk, arst_n, (s_tvalid && s_tready && s_tlast) |=> (phase_q == PH_CODE), "parser not restarted after frame end")

endmodule
`default_nettype wire

>>> sim/dhcp_option_extractor_checker.sv
// Scoreboard for the DHCP option extractor: predicts every options summary and checks the result stream.
`default_nettype none
module dhcp_option_extractor_checker
	import dhcpx_pkg::*;
#(
	parameter int DNS_SLOTS = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	input  wire logic                 s_tready,
	input  wire logic [7:0]           s_tdata,   // [7:0] option_byte
	input  wire logic                 s_tlast,   // frame_end
	input  wire logic                 m_tvalid,
	input  wire logic                 m_tready,
	// [3:0] message_type, [35:4] server_ident, [36] server_ident_ok,
	// [68:37] lease_seconds, [69] lease_ok, [101:70] net_mask, [102] net_mask_ok,
	// [104:103] dns_count, [136:105] dns_first, [168:137] dns_second,
	// [200:169] dns_third, [207:201] zero
	input  wire logic [RES_WIDTH-1:0] m_tdata,
	input  wire logic                 m_tuser,   // malformed
	output int                        fail_count,
	output int                        open_results,
	output int                        result_count,
	output int                        malformed_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// Result word laid out as on m_tdata, highest field first
	typedef struct packed {
		logic [6:0]  zero_fill;
		logic [31:0] dns_third;
		logic [31:0] dns_second;
		logic [31:0] dns_first;
		logic [1:0]  dns_count;
		logic        mask_ok;
		logic [31:0] mask;
		logic        lease_ok;
		logic [31:0] lease;
		logic        server_ok;
		logic [31:0] server;
		logic [3:0]  msg_type;
	} summary_t;

	typedef struct packed {
		logic     malformed;
		summary_t s;
	} outcome_t;

	// Parser state of the prediction
	logic [1:0]  phase_r;
	logic [7:0]  opt_code;
	logic [7:0]  remain;
	logic [7:0]  val_idx;
	logic [31:0] val_acc;
	logic [3:0]  type_keep;
	logic [31:0] srv_keep, lease_keep, mask_keep;
	logic        srv_valid, lease_valid, mask_valid;
	logic [1:0]  dns_keep_n;
	logic [31:0] dns_addr [DNS_SLOTS];

	outcome_t summaries_due [$];

	// Drop everything learned about the current message
	task automatic forget_message();
		phase_r     = PH_CODE;
		opt_code    = '0;
		remain      = '0;
		val_idx     = '0;
		val_acc     = '0;
		type_keep   = '0;
		srv_keep    = '0;
		srv_valid   = 1'b0;
		lease_keep  = '0;
		lease_valid = 1'b0;
		mask_keep   = '0;
		mask_valid  = 1'b0;
		dns_keep_n  = '0;
	endtask

	// Keep the option that just completed; its length is the value byte count
	task automatic store_option();
		logic [7:0] len;
		int n;
		len = val_idx;
		case (opt_code)
			OPT_TYPE: begin
				type_keep = (len == 8'd1 && val_acc >= 32'd1 && val_acc <= MSG_TYPE_MAX) ?
					val_acc[3:0] : 4'd0;
			end
			OPT_SERVER: begin
				srv_valid = (len == ADDR_LEN);
				srv_keep  = srv_valid ? val_acc : '0;
			end
			OPT_LEASE: begin
				lease_valid = (len == ADDR_LEN);
				lease_keep  = lease_valid ? val_acc : '0;
			end
			OPT_MASK: begin
				mask_valid = (len == ADDR_LEN);
				mask_keep  = mask_valid ? val_acc : '0;
			end
			OPT_DNS: begin
				n = 0;
				if (len % ADDR_LEN == 0) n = len / ADDR_LEN;
				if (n > DNS_SLOTS) n = DNS_SLOTS;
				if (n > 3) n = 3;
				dns_keep_n = 2'(n);
			end
			default: ;
		endcase
		phase_r = PH_CODE;
	endtask

	// Queue the summary of what is kept now
	task automatic expect_summary(input logic flagged);
		outcome_t o;
		o = '0;
		o.malformed   = flagged;
		o.s.msg_type  = type_keep;
		o.s.server    = srv_keep;
		o.s.server_ok = srv_valid;
		o.s.lease     = lease_keep;
		o.s.lease_ok  = lease_valid;
		o.s.mask      = mask_keep;
		o.s.mask_ok   = mask_valid;
		o.s.dns_count = dns_keep_n;
		if (dns_keep_n >= 2'd1) o.s.dns_first = dns_addr[0];
		if (dns_keep_n >= 2'd2) o.s.dns_second = dns_addr[1];
		if (dns_keep_n >= 2'd3) o.s.dns_third = dns_addr[2];
		summaries_due.push_back(o);
	endtask

	// Advance the parse by one accepted option byte
	task automatic parse_byte(input logic [7:0] b, input logic last);
		logic emitted;
		int slot;
		emitted = 1'b0;
		case (phase_r)
			PH_CODE: begin
				if (b == OPT_END) begin
					expect_summary(1'b0);
					emitted = 1'b1;
					forget_message();
					phase_r = PH_DRAIN;
				end else if (b != OPT_PAD) begin
					opt_code = b;
					phase_r  = PH_LEN;
				end
			end
			PH_LEN: begin
				remain  = b;
				val_idx = '0;
				val_acc = '0;
				if (b == 8'd0) store_option();
				else phase_r = PH_VALUE;
			end
			PH_VALUE: begin
				val_acc = {val_acc[23:0], b};
				// a DNS address completes on every fourth value byte
				slot = val_idx >> 2;
				if (opt_code == OPT_DNS && val_idx[1:0] == 2'd3 && slot < DNS_SLOTS)
					dns_addr[slot] = val_acc;
				val_idx = val_idx + 8'd1;
				remain  = remain - 8'd1;
				if (remain == 8'd0) store_option();
			end
			default: ;
		endcase
		// frame end without END reports what was kept, then starts over
		if (last) begin
			if (!emitted && phase_r != PH_DRAIN) expect_summary(1'b1);
			forget_message();
		end
	endtask

	function automatic int field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Check result requests, then predict from option byte requests
	always @(posedge clk or negedge arst_n) begin : watch_b
		summary_t got;
		outcome_t want;
		int wrong;
		if (!arst_n) begin
			forget_message();
			foreach (dns_addr[k]) dns_addr[k] = '0;
			summaries_due.delete();
			fail_count     = 0;
			open_results   = 0;
			result_count   = 0;
			malformed_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				result_count++;
				if (m_tuser) malformed_seen++;
				if (summaries_due.size() == 0) begin
					$display("%0t ns: result with nothing expected, got %0h malformed %0b",
						$time, m_tdata, m_tuser);
					fail_count++;
				end else begin
					want  = summaries_due.pop_front();
					wrong = 0;
					wrong += field_differs("message_type", want.s.msg_type, got.msg_type);
					wrong += field_differs("server_ident", want.s.server, got.server);
					wrong += field_differs("server_ident_ok", want.s.server_ok, got.server_ok);
					wrong += field_differs("lease_seconds", want.s.lease, got.lease);
					wrong += field_differs("lease_ok", want.s.lease_ok, got.lease_ok);
					wrong += field_differs("net_mask", want.s.mask, got.mask);
					wrong += field_differs("net_mask_ok", want.s.mask_ok, got.mask_ok);
					wrong += field_differs("dns_count", want.s.dns_count, got.dns_count);
					wrong += field_differs("dns_first", want.s.dns_first, got.dns_first);
					wrong += field_differs("dns_second", want.s.dns_second, got.dns_second);
					wrong += field_differs("dns_third", want.s.dns_third, got.dns_third);
					wrong += field_differs("zero fill", want.s.zero_fill, got.zero_fill);
					wrong += field_differs("malformed", want.malformed, m_tuser);
					if (wrong != 0) fail_count++;
				end
			end
			if (s_tvalid && s_tready) parse_byte(s_tdata, s_tlast);
			open_results = summaries_due.size();
		end
	end

endmodule
`default_nettype wire

>>> sim/tb_dhcp_option_extractor.sv
// Testbench top for the DHCP option extractor: byte stimulus, result back-pressure and verdict.
`default_nettype none
module tb_dhcp_option_extractor;
	import dhcpx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DNS_SLOTS    = 3;
	localparam int ITEM_TARGET  = 700;
	localparam int LIMIT_CYCLES = 400000;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata  = '0;    // [7:0] option_byte
	logic                 s_tlast  = 1'b0;  // frame_end
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [RES_WIDTH-1:0] m_tdata;          // summary fields, message_type lowest
	logic                 m_tuser;          // malformed

	int fail_count, open_results, result_count, malformed_seen;
	int cycle_count   = 0;
	int bytes_sent    = 0;
	int ignored_bytes = 0;
	int msg_count     = 0;
	int stall_left    = 0;
	int stall_roll;
	bit steady        = 1'b0;

	logic [7:0] frame_q [$];

	dhcp_option_extractor #(
		.DNS_SLOT_COUNT(DNS_SLOTS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	dhcp_option_extractor_checker #(
		.DNS_SLOTS(DNS_SLOTS)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.fail_count    (fail_count),
		.open_results  (open_results),
		.result_count  (result_count),
		.malformed_seen(malformed_seen)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, open_results);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stall the result side: mostly short holds, now and then a long one
	always @(negedge clk) begin
		if (steady) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			stall_roll = $urandom_range(0, 99);
			if (stall_roll < 20) stall_left = $urandom_range(1, 3);
			else if (stall_roll < 23) stall_left = $urandom_range(10, 40);
		end
	end

	// Offer one byte after a random gap and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		gap = steady ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// Send the assembled message, frame_end on its last byte
	task automatic send_frame();
		for (int k = 0; k < frame_q.size(); k++) send_byte(frame_q[k], k == frame_q.size() - 1);
		bytes_sent += frame_q.size();
		frame_q.delete();
		msg_count++;
	endtask

	// Append one code/length/value record with random value bytes
	task automatic put_option(input logic [7:0] code, input int len);
		frame_q.push_back(code);
		frame_q.push_back(8'(len));
		repeat (len) begin
			frame_q.push_back((code == OPT_TYPE && $urandom_range(0, 3) != 0) ?
				8'($urandom_range(0, 9)) : 8'($urandom));
		end
	endtask

	initial begin
		int shape, pick, len, cut, tail, r;
		logic [7:0] code;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// highest message type, all-ones lease, zero-length mask, a second END after END
		frame_q = '{OPT_TYPE, 8'd1, 8'd8, OPT_LEASE, ADDR_LEN, 8'hff, 8'hff, 8'hff, 8'hff,
			OPT_MASK, 8'd0, OPT_END, OPT_END};
		send_frame();
		// pad, wrong-length type, frame cut inside the server identifier value
		frame_q = '{OPT_PAD, OPT_TYPE, 8'd2, 8'd1, 8'd2};
		put_option(OPT_SERVER, 4);
		void'(frame_q.pop_back());
		void'(frame_q.pop_back());
		send_frame();
		// out-of-range type, END arriving with frame_end
		frame_q = '{OPT_TYPE, 8'd1, 8'd9, OPT_END};
		send_frame();

		// random messages: mostly well formed, some cut short, some pure noise
		while (bytes_sent - ignored_bytes < ITEM_TARGET) begin
			steady = (msg_count % 12) < 2;
			// hold off now and then until every summary has come back
			if (msg_count % 16 == 0 && open_results != 0) begin
				s_tvalid <= 1'b0;
				while (open_results != 0) @(negedge clk);
			end
			shape = $urandom_range(0, 99);
			if (shape < 12) begin
				repeat ($urandom_range(1, 16)) frame_q.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 5)) begin
					pick = $urandom_range(0, 6);
					case (pick)
						1: code = OPT_TYPE;
						2: code = OPT_SERVER;
						3: code = OPT_LEASE;
						4: code = OPT_MASK;
						5: code = OPT_DNS;
						default: code = 8'($urandom_range(1, 254));
					endcase
					r = $urandom_range(0, 99);
					if (code == OPT_TYPE) len = (r < 80) ? 1 : $urandom_range(0, 3);
					else if (code == OPT_DNS) len = (r < 75) ? 4 * $urandom_range(0, 5) :
						$urandom_range(0, 13);
					else if (code == OPT_SERVER || code == OPT_LEASE || code == OPT_MASK)
						len = (r < 80) ? ADDR_LEN : $urandom_range(0, 7);
					else len = $urandom_range(0, 6);
					if ($urandom_range(0, 149) == 0) len = $urandom_range(200, 255);
					if (pick == 0) frame_q.push_back(OPT_PAD);
					else put_option(code, len);
				end
				if (shape < 30) begin
					// cut the frame short, possibly inside a record
					cut = $urandom_range(1, frame_q.size());
					while (frame_q.size() > cut) void'(frame_q.pop_back());
				end else begin
					frame_q.push_back(OPT_END);
					tail = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
					ignored_bytes += tail;
					repeat (tail) frame_q.push_back(8'($urandom));
				end
			end
			send_frame();
		end
		s_tvalid <= 1'b0;
		steady = 1'b0;

		// drain, then allow for the result register
		while (open_results != 0) @(negedge clk);
		repeat (16) @(negedge clk);

		$display("Sent %0d option bytes (%0d ignored after END) in %0d messages.",
			bytes_sent, ignored_bytes, msg_count);
		$display("Compared %0d summaries, %0d of them flagged malformed.",
			result_count, malformed_seen);
		if (fail_count == 0 && open_results == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
`default_nettype wire

>>> files.f
+incdir+design
design/dhcpx_pkg.sv
design/dhcp_option_extractor.sv
sim/dhcp_option_extractor_checker.sv
sim/tb_dhcp_option_extractor.sv
